>>> rtl/core/ahcs_pkg.sv
package ahcs_pkg;

    localparam int unsigned MAX_AGENTS     = 65536;
    localparam int unsigned MAX_HOSPITALS  = 256;
    localparam int unsigned MAX_CEMETERIES = 256;

    localparam int unsigned AGENT_W = 16;
    localparam int unsigned REGION_W = 16;
    localparam int unsigned DIS_W   = 17;
    localparam int unsigned LOC_W   = 32;
    localparam int unsigned TIDX_W  = 8;
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned CNT_W   = 9;
    localparam int unsigned REM_W   = 8;
    localparam int unsigned STEP_W  = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned CMD_W   = 3;

    localparam logic [DIS_W-1:0] ONE_FIXED = 17'h10000;
    localparam logic [CNT_W-1:0] HOSP_CAP  = 9'd256;
    localparam logic [CNT_W-1:0] CEM_CAP   = 9'd256;

    localparam int unsigned ROT_A   = 24;
    localparam int unsigned SHIFT_B = 16;
    localparam int unsigned ROT_B   = 37;

    localparam logic [CMD_W-1:0] CMD_HOSP_STEP = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CEM_STEP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_HOSP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_LOAD_CEM  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LOAD_W0   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LOAD_W1   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOSP_CNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEM_CNT   = 2'd3;

    typedef struct packed {
        logic load0;
        logic load1;
        logic draw;
    } t_prng_ctl;

endpackage

>>> rtl/core/ahcs_ram.sv
module ahcs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/ahcs_prng.sv
module ahcs_prng (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ahcs_pkg::t_prng_ctl          i_ctl,
    input  logic [ahcs_pkg::WORD_W-1:0]  i_value,
    output logic [ahcs_pkg::WORD_W-1:0]  o_sum
);

    logic [ahcs_pkg::WORD_W-1:0] r_w0;
    logic [ahcs_pkg::WORD_W-1:0] r_w1;
    logic [ahcs_pkg::WORD_W-1:0] n_w0;
    logic [ahcs_pkg::WORD_W-1:0] n_w1;
    logic [ahcs_pkg::WORD_W-1:0] mix;

    // xoroshiro128+ step
    always_comb begin
        mix  = r_w1 ^ r_w0;
        n_w0 = r_w0;
        n_w1 = r_w1;
        if (i_ctl.draw) begin
            n_w0 = {r_w0[ahcs_pkg::WORD_W-ahcs_pkg::ROT_A-1:0],
                    r_w0[ahcs_pkg::WORD_W-1:ahcs_pkg::WORD_W-ahcs_pkg::ROT_A]}
                   ^ mix ^ (mix << ahcs_pkg::SHIFT_B);
            n_w1 = {mix[ahcs_pkg::WORD_W-ahcs_pkg::ROT_B-1:0],
                    mix[ahcs_pkg::WORD_W-1:ahcs_pkg::WORD_W-ahcs_pkg::ROT_B]};
        end
        if (i_ctl.load0) begin
            n_w0 = i_value;
        end
        if (i_ctl.load1) begin
            n_w1 = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0 <= '0;
            r_w1 <= '0;
        end else begin
            r_w0 <= n_w0;
            r_w1 <= n_w1;
        end
    end

    assign o_sum = r_w0 + r_w1;

endmodule

>>> rtl/core/ahcs_mod.sv
module ahcs_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ahcs_pkg::WORD_W-1:0]  i_dividend,
    input  logic [ahcs_pkg::CNT_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [ahcs_pkg::REM_W-1:0]   o_rem
);

    logic                         r_busy;
    logic                         r_done;
    logic [ahcs_pkg::STEP_W-1:0]  r_step;
    logic [ahcs_pkg::WORD_W-1:0]  r_dvd;
    logic [ahcs_pkg::CNT_W-1:0]   r_div;
    logic [ahcs_pkg::REM_W-1:0]   r_rem;
    logic [ahcs_pkg::CNT_W-1:0]   trial;
    logic [ahcs_pkg::CNT_W-1:0]   n_part;

    // restoring remainder, one dividend bit per cycle, MSB first
    always_comb begin
        trial  = {r_rem, r_dvd[ahcs_pkg::WORD_W-1]};
        n_part = (trial >= r_div) ? trial - r_div : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == {ahcs_pkg::STEP_W{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[ahcs_pkg::WORD_W-2:0], 1'b0};
            r_rem <= n_part[ahcs_pkg::REM_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/agent_hospital_cemetery_step.sv
// Loads and skipped items go from ST_IDLE straight to ST_OUT; discharges and agents
// already admitted or buried pass through ST_FLAG first; a draw also runs the serial
// remainder unit in ST_MOD, then ST_TRD and ST_TUSE. One item at a time: input is
// stalled until the result is loaded into the output register; output stall delays that.
// Reset: synchronous, active low; then a pass over all 65536 entries clears the agent flag
// memory, during which no input transfer is taken.
module agent_hospital_cemetery_step (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ahcs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ahcs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ahcs_pkg::CMD_W-1:0]          i_cmd,
    input  logic [ahcs_pkg::AGENT_W-1:0]        i_agent,
    input  logic [ahcs_pkg::REGION_W-1:0]       i_region,
    input  logic                                i_requesting,
    input  logic [ahcs_pkg::DIS_W-1:0]          i_disease,
    input  logic [ahcs_pkg::LOC_W-1:0]          i_current_place,
    input  logic [ahcs_pkg::TIDX_W-1:0]         i_table_index,
    input  logic [ahcs_pkg::WORD_W-1:0]         i_load_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_location_write,
    output logic [ahcs_pkg::LOC_W-1:0]          o_new_location,
    output logic                                o_facemask_write
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_FLAG  = 3'd2;
    localparam logic [2:0] ST_MOD   = 3'd3;
    localparam logic [2:0] ST_TRD   = 3'd4;
    localparam logic [2:0] ST_TUSE  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    localparam logic [ahcs_pkg::CNT_W-1:0] HOSP_CAP_L = ahcs_pkg::HOSP_CAP;
    localparam logic [ahcs_pkg::CNT_W-1:0] CEM_CAP_L  = ahcs_pkg::CEM_CAP;

    logic [2:0]                          r_state, n_state;
    logic [ahcs_pkg::AGENT_W-1:0]        r_clr_addr;
    logic                                r_cem, n_cem;
    logic                                r_hot, n_hot;
    logic [ahcs_pkg::AGENT_W-1:0]        r_agent, n_agent;
    logic [ahcs_pkg::LOC_W-1:0]          r_place, n_place;
    logic [1:0]                          r_flags, n_flags;
    logic                                r_wr, n_wr;
    logic [ahcs_pkg::LOC_W-1:0]          r_loc, n_loc;
    logic                                r_mask, n_mask;
    logic                                r_out_valid;
    logic                                r_out_wr;
    logic [ahcs_pkg::LOC_W-1:0]          r_out_loc;
    logic                                r_out_mask;

    logic [ahcs_pkg::REGION_W-1:0]       r_region_id;
    logic [ahcs_pkg::DIS_W-1:0]          r_threshold;
    logic [ahcs_pkg::CNT_W-1:0]          r_hosp_cnt;
    logic [ahcs_pkg::CNT_W-1:0]          r_cem_cnt;

    logic                                accept;
    logic                                out_take;
    logic                                out_load;
    logic [ahcs_pkg::CNT_W-1:0]          hosp_sat;
    logic [ahcs_pkg::CNT_W-1:0]          cem_sat;
    logic                                active;

    logic                                flag_we;
    logic [ahcs_pkg::AGENT_W-1:0]        flag_waddr;
    logic [1:0]                          flag_wdata;
    logic [1:0]                          flag_rdata;
    logic                                hosp_we;
    logic                                cem_we;
    logic [ahcs_pkg::LOC_W-1:0]          hosp_rdata;
    logic [ahcs_pkg::LOC_W-1:0]          cem_rdata;

    ahcs_pkg::t_prng_ctl                 prng_ctl;
    logic [ahcs_pkg::WORD_W-1:0]         prng_sum;
    logic                                mod_start;
    logic                                mod_done;
    logic [ahcs_pkg::REM_W-1:0]          mod_rem;

    assign accept     = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_take   = r_out_valid && !i_out_stall;
    assign out_load   = (r_state == ST_OUT) && (!r_out_valid || out_take);

    assign hosp_sat = (r_hosp_cnt > HOSP_CAP_L) ? HOSP_CAP_L : r_hosp_cnt;
    assign cem_sat  = (r_cem_cnt > CEM_CAP_L) ? CEM_CAP_L : r_cem_cnt;

    assign active = (i_region == r_region_id) && i_requesting;

    assign hosp_we = accept && (i_cmd == ahcs_pkg::CMD_LOAD_HOSP);
    assign cem_we  = accept && (i_cmd == ahcs_pkg::CMD_LOAD_CEM);

    always_comb begin
        n_state    = r_state;
        n_cem      = r_cem;
        n_hot      = r_hot;
        n_agent    = r_agent;
        n_place    = r_place;
        n_flags    = r_flags;
        n_wr       = r_wr;
        n_loc      = r_loc;
        n_mask     = r_mask;
        flag_we    = 1'b0;
        flag_waddr = r_agent;
        flag_wdata = r_flags;
        prng_ctl   = '0;
        mod_start  = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                flag_we    = 1'b1;
                flag_waddr = r_clr_addr;
                flag_wdata = '0;
                if (r_clr_addr == {ahcs_pkg::AGENT_W{1'b1}}) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_cem   = (i_cmd == ahcs_pkg::CMD_CEM_STEP);
                    n_hot   = (i_disease > r_threshold);
                    n_agent = i_agent;
                    n_place = i_current_place;
                    n_wr    = 1'b0;
                    n_loc   = '0;
                    n_mask  = 1'b0;
                    n_state = ST_OUT;
                    prng_ctl.load0 = (i_cmd == ahcs_pkg::CMD_LOAD_W0);
                    prng_ctl.load1 = (i_cmd == ahcs_pkg::CMD_LOAD_W1);
                    if (i_cmd == ahcs_pkg::CMD_HOSP_STEP && active && hosp_sat != '0) begin
                        n_state = ST_FLAG;
                    end
                    if (i_cmd == ahcs_pkg::CMD_CEM_STEP && active && cem_sat != '0
                            && i_disease == ahcs_pkg::ONE_FIXED) begin
                        n_state = ST_FLAG;
                    end
                end
            end
            ST_FLAG: begin
                n_flags = flag_rdata;
                if (!r_cem) begin
                    if (r_hot) begin
                        if (!flag_rdata[0]) begin
                            prng_ctl.draw = 1'b1;
                            mod_start     = 1'b1;
                            n_state       = ST_MOD;
                        end else begin
                            n_wr    = 1'b1;
                            n_mask  = 1'b1;
                            n_loc   = r_place;
                            n_state = ST_OUT;
                        end
                    end else begin
                        // discharge
                        flag_we    = 1'b1;
                        flag_wdata = {flag_rdata[1], 1'b0};
                        n_state    = ST_OUT;
                    end
                end else begin
                    if (!flag_rdata[1]) begin
                        prng_ctl.draw = 1'b1;
                        mod_start     = 1'b1;
                        n_state       = ST_MOD;
                    end else begin
                        n_wr    = 1'b1;
                        n_loc   = r_place;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    n_state = ST_TRD;
                end
            end
            ST_TRD: begin
                n_state = ST_TUSE;
            end
            ST_TUSE: begin
                flag_we = 1'b1;
                n_wr    = 1'b1;
                n_mask  = !r_cem;
                n_loc   = r_cem ? cem_rdata : hosp_rdata;
                flag_wdata = r_cem ? {1'b1, r_flags[0]} : {r_flags[1], 1'b1};
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_region_id <= '0;
            r_threshold <= ahcs_pkg::ONE_FIXED;
            r_hosp_cnt  <= '0;
            r_cem_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ahcs_pkg::CFG_REGION:    r_region_id <= i_cfg_data[ahcs_pkg::REGION_W-1:0];
                    ahcs_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[ahcs_pkg::DIS_W-1:0];
                    ahcs_pkg::CFG_HOSP_CNT:  r_hosp_cnt  <= i_cfg_data[ahcs_pkg::CNT_W-1:0];
                    ahcs_pkg::CFG_CEM_CNT:   r_cem_cnt   <= i_cfg_data[ahcs_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cem   <= n_cem;
        r_hot   <= n_hot;
        r_agent <= n_agent;
        r_place <= n_place;
        r_flags <= n_flags;
        r_wr    <= n_wr;
        r_loc   <= n_loc;
        r_mask  <= n_mask;
        if (out_load) begin
            r_out_wr   <= r_wr;
            r_out_loc  <= r_loc;
            r_out_mask <= r_mask;
        end
    end

    // bit 0 admitted, bit 1 buried
    ahcs_ram #(
        .WIDTH(2),
        .DEPTH(ahcs_pkg::MAX_AGENTS)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (flag_waddr),
        .i_wdata (flag_wdata),
        .i_raddr (i_agent),
        .o_rdata (flag_rdata)
    );

    ahcs_ram #(
        .WIDTH(ahcs_pkg::LOC_W),
        .DEPTH(ahcs_pkg::MAX_HOSPITALS)
    ) u_hosp_ram (
        .i_clk   (i_clk),
        .i_we    (hosp_we),
        .i_waddr (i_table_index),
        .i_wdata (i_load_value[ahcs_pkg::LOC_W-1:0]),
        .i_raddr (mod_rem),
        .o_rdata (hosp_rdata)
    );

    ahcs_ram #(
        .WIDTH(ahcs_pkg::LOC_W),
        .DEPTH(ahcs_pkg::MAX_CEMETERIES)
    ) u_cem_ram (
        .i_clk   (i_clk),
        .i_we    (cem_we),
        .i_waddr (i_table_index),
        .i_wdata (i_load_value[ahcs_pkg::LOC_W-1:0]),
        .i_raddr (mod_rem),
        .o_rdata (cem_rdata)
    );

    ahcs_prng u_prng (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (prng_ctl),
        .i_value (i_load_value),
        .o_sum   (prng_sum)
    );

    ahcs_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (prng_sum),
        .i_divisor  (r_cem ? cem_sat : hosp_sat),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign o_out_valid      = r_out_valid;
    assign o_location_write = r_out_wr;
    assign o_new_location   = r_out_loc;
    assign o_facemask_write = r_out_mask;

endmodule
